/* hw/rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types and constants of the text console writer
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // fixed field widths of the console ports
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned CELL_W = 2 * CHAR_W;

  localparam logic [CHAR_W-1:0] CHAR_CR  = 8'h0d;
  localparam logic [CHAR_W-1:0] CHAR_LF  = 8'h0a;
  localparam logic [CHAR_W-1:0] CHAR_TAB = 8'h09;

  localparam logic [CHAR_W-1:0] ATTR_RESET = 8'd13;

  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // depth of the command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_PUT     = 2'd0,
    CMD_NEWLINE = 2'd1,
    CMD_TAB     = 2'd2,
    CMD_READ    = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e              kind;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } cmd_t;

  typedef struct packed {
    logic              wrote_cell;
    logic [ROW_W-1:0]  cell_row;
    logic [COL_W-1:0]  cell_col;
    logic [CHAR_W-1:0] cell_char;
    logic [CHAR_W-1:0] cell_attr;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic              scrolled;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/text_console_writer_unit.sv */
// ----------------------------------------------------------------------------
// text_console_writer_unit
// text console: prints bytes into a character frame store, reads cells back
// ----------------------------------------------------------------------------
// results: a put or an out-of-range read reaches the ports through the command
//   queue and the result register, an in-range read also through the ram read
//   data register; one item per cycle from the command queue while the result
//   slot is free, an in-range read passes ST_READ first; a put that finds a
//   scroll pending first copies the rows up through the one ram port pair
// reset: after reset a clearing pass over all ROWS*COLUMNS cells zeroes the
//   frame store; full stays high meanwhile, config writes still land
`default_nettype none

module text_console_writer_unit #(
  parameter int unsigned COLUMNS  = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned TAB_STOP = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // attribute register write
  input  wire logic                        cfg_we_i,
  input  wire logic [tcw_pkg::CHAR_W-1:0]  cfg_wdata_i,
  // input side
  input  wire logic                        push,
  output logic                             full,
  input  wire logic                        kind_i,
  input  wire logic [tcw_pkg::CHAR_W-1:0]  char_code_i,
  input  wire logic [tcw_pkg::ROW_W-1:0]   read_row_i,
  input  wire logic [tcw_pkg::COL_W-1:0]   read_col_i,
  // result side
  output logic                             empty,
  input  wire logic                        pop,
  output logic                             wrote_cell_o,
  output logic      [tcw_pkg::ROW_W-1:0]   cell_row_o,
  output logic      [tcw_pkg::COL_W-1:0]   cell_col_o,
  output logic      [tcw_pkg::CHAR_W-1:0]  cell_char_o,
  output logic      [tcw_pkg::CHAR_W-1:0]  cell_attr_o,
  output logic      [tcw_pkg::ROW_W-1:0]   cursor_row_o,
  output logic      [tcw_pkg::COL_W-1:0]   cursor_col_o,
  output logic                             scrolled_o
);
  import tcw_pkg::*;

  // attribute byte stored with every printed character
  logic [CHAR_W-1:0] attr_q;

  // queue head between front and back
  logic head_valid;
  cmd_t head;
  logic head_pop;
  logic clearing;

  // result slot
  logic res_valid;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  // front: takes transfers, sorts bytes into put, newline and tab commands, reads into read commands
  tcw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .kind_i       (kind_i),
    .char_code_i  (char_code_i),
    .read_row_i   (read_row_i),
    .read_col_i   (read_col_i),
    .hold_i       (clearing),
    .head_valid_o (head_valid),
    .head_o       (head),
    .head_pop_i   (head_pop)
  );

  // back: cursor, scroll copy, frame store access and the result register
  tcw_back #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .attr_i       (attr_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .clearing_o   (clearing),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_pop_i    (pop)
  );

  // result ports straight from the result register
  assign empty        = !res_valid;
  assign wrote_cell_o = res.wrote_cell;
  assign cell_row_o   = res.cell_row;
  assign cell_col_o   = res.cell_col;
  assign cell_char_o  = res.cell_char;
  assign cell_attr_o  = res.cell_attr;
  assign cursor_row_o = res.cursor_row;
  assign cursor_col_o = res.cursor_col;
  assign scrolled_o   = res.scrolled;

endmodule

`default_nettype wire

/* hw/rtl/tcw_ram.sv */
// ----------------------------------------------------------------------------
// tcw_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/tcw_front.sv */
// ----------------------------------------------------------------------------
// tcw_front
// accepts items, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic                        kind_i,
  input  wire logic [tcw_pkg::CHAR_W-1:0]  char_code_i,
  input  wire logic [tcw_pkg::ROW_W-1:0]   read_row_i,
  input  wire logic [tcw_pkg::COL_W-1:0]   read_col_i,
  input  wire logic                        hold_i,
  output logic                             head_valid_o,
  output tcw_pkg::cmd_t                    head_o,
  input  wire logic                        head_pop_i
);
  import tcw_pkg::*;

  localparam int unsigned PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned NW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          ent_q [CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] cnt_q, cnt_d;
  cmd_t          cmd;
  logic          do_push;
  logic          do_pop;

  // classify the incoming byte
  always_comb begin
    cmd.char_code = char_code_i;
    cmd.read_row  = read_row_i;
    cmd.read_col  = read_col_i;
    if (kind_i == KIND_READ) begin
      cmd.kind = CMD_READ;
    end else if (char_code_i == CHAR_CR || char_code_i == CHAR_LF) begin
      cmd.kind = CMD_NEWLINE;
    end else if (char_code_i == CHAR_TAB) begin
      cmd.kind = CMD_TAB;
    end else begin
      cmd.kind = CMD_PUT;
    end
  end

  assign full         = (cnt_q == NW'(CMDQ_DEPTH)) || hold_i;
  assign do_push      = push && !full;
  assign head_valid_o = (cnt_q != '0);
  assign do_pop       = head_pop_i && head_valid_o;
  assign head_o       = ent_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= cmd;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tcw_back.sv */
// ----------------------------------------------------------------------------
// tcw_back
// executes queued commands on the frame store and holds the result slot
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back #(
  parameter int unsigned COLUMNS  = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned TAB_STOP = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [tcw_pkg::CHAR_W-1:0]  attr_i,
  input  wire logic                        head_valid_i,
  input  wire tcw_pkg::cmd_t               head_i,
  output logic                             head_pop_o,
  output logic                             clearing_o,
  output logic                             res_valid_o,
  output tcw_pkg::res_t                    res_o,
  input  wire logic                        res_pop_i
);
  import tcw_pkg::*;

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned SW    = $clog2(CELLS + 1);
  localparam int unsigned RW    = $clog2(ROWS + 1);
  localparam int unsigned CW    = $clog2(COLUMNS + 1);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_RUN    = 4'b0010,
    ST_SCROLL = 4'b0100,
    ST_READ   = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [SW-1:0]     scr_q, scr_d;
  logic              wr_pend_q, wr_pend_d;
  logic              scr_pend_q, scr_pend_d;
  logic [RW-1:0]     row_q, row_d;
  logic [CW-1:0]     col_q, col_d;
  logic              res_valid_q, res_valid_d;
  res_t              res_q, res_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  logic [CW-1:0]     tab_col;
  logic              tab_wrap;
  logic              slot_free;
  logic              read_in_range;
  logic [CW-1:0]     col_inc;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next tab stop per column, a constant table
  always_comb begin
    int t;
    tab_col  = '0;
    tab_wrap = 1'b0;
    for (int i = 0; i < COLUMNS; i++) begin
      t = (i / TAB_STOP + 1) * TAB_STOP;
      if (col_q == CW'(i)) begin
        if (t >= COLUMNS) begin
          tab_wrap = 1'b1;
          t        = t - COLUMNS;
          if (t >= COLUMNS) begin
            t = 0;
          end
        end
        tab_col = CW'(t);
      end
    end
  end

  assign slot_free     = !res_valid_q || res_pop_i;
  assign read_in_range = (32'(head_i.read_row) < ROWS) && (32'(head_i.read_col) < COLUMNS);
  assign col_inc       = col_q + CW'(1);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    scr_d       = scr_q;
    wr_pend_d   = 1'b0;
    scr_pend_d  = scr_pend_q;
    row_d       = row_q;
    col_d       = col_q;
    res_valid_d = res_valid_q && !res_pop_i;
    res_d       = res_q;
    head_pop_o  = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = clr_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = AW'(32'(head_i.read_row) * COLUMNS + 32'(head_i.read_col));

    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (clr_q == AW'(CELLS - 1)) begin
          state_d = ST_RUN;
        end
      end

      ST_RUN: begin
        if (head_valid_i && slot_free) begin
          res_d            = '0;
          res_d.cursor_row = ROW_W'(row_q);
          res_d.cursor_col = COL_W'(col_q);
          if (head_i.kind == CMD_READ) begin
            head_pop_o     = 1'b1;
            res_d.cell_row = head_i.read_row;
            res_d.cell_col = head_i.read_col;
            if (read_in_range) begin
              ram_re  = 1'b1;
              state_d = ST_READ;
            end else begin
              res_valid_d = 1'b1;
            end
          end else if (row_q == RW'(ROWS)) begin
            // scroll first, the put stays at the queue head
            scr_d   = SW'(COLUMNS);
            state_d = ST_SCROLL;
          end else begin
            head_pop_o     = 1'b1;
            res_valid_d    = 1'b1;
            res_d.scrolled = scr_pend_q;
            scr_pend_d     = 1'b0;
            case (head_i.kind)
              CMD_NEWLINE: begin
                row_d = row_q + RW'(1);
                col_d = '0;
              end
              CMD_TAB: begin
                col_d = tab_col;
                row_d = row_q + RW'(tab_wrap);
              end
              CMD_PUT: begin
                ram_we          = 1'b1;
                ram_waddr       = AW'(32'(row_q) * COLUMNS + 32'(col_q));
                ram_wdata       = {attr_i, head_i.char_code};
                res_d.wrote_cell = 1'b1;
                res_d.cell_row  = ROW_W'(row_q);
                res_d.cell_col  = COL_W'(col_q);
                res_d.cell_char = head_i.char_code;
                res_d.cell_attr = attr_i;
                if (col_inc == CW'(COLUMNS)) begin
                  col_d = '0;
                  row_d = row_q + RW'(1);
                end else begin
                  col_d = col_inc;
                end
              end
              default: begin
              end
            endcase
            res_d.cursor_row = ROW_W'(row_d);
            res_d.cursor_col = COL_W'(col_d);
          end
        end
      end

      ST_SCROLL: begin
        // read one row ahead, write the data back in the cycle after
        if (wr_pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(32'(scr_q) - COLUMNS - 1);
          ram_wdata = ram_rdata;
        end
        if (32'(scr_q) < CELLS) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(scr_q);
          scr_d     = scr_q + SW'(1);
          wr_pend_d = 1'b1;
        end else begin
          row_d      = RW'(ROWS - 1);
          scr_pend_d = 1'b1;
          state_d    = ST_RUN;
        end
      end

      ST_READ: begin
        res_d.cell_char = ram_rdata[CHAR_W-1:0];
        res_d.cell_attr = ram_rdata[CELL_W-1:CHAR_W];
        res_valid_d     = 1'b1;
        state_d         = ST_RUN;
      end

      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      scr_q       <= '0;
      wr_pend_q   <= 1'b0;
      scr_pend_q  <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      scr_q       <= scr_d;
      wr_pend_q   <= wr_pend_d;
      scr_pend_q  <= scr_pend_d;
      row_q       <= row_d;
      col_q       <= col_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign clearing_o  = (state_q == ST_CLEAR);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire
